// ===== rtl/core/nqse_pkg.sv =====
// ----------------------------------------------------------------------------
// nqse_pkg
// Shared constants, types and the controller/datapath interface of the
// N-queens solution enumerator.
// ----------------------------------------------------------------------------
package nqse_pkg;

    localparam int MAX_N      = 10;
    localparam int ROW_W      = $clog2(MAX_N);
    localparam int CNT_W      = $clog2(MAX_N + 1);
    localparam int DIAG_W     = 2 * MAX_N - 1;
    localparam int DIDX_W     = $clog2(DIAG_W);

    localparam int SIZE_W     = 4;
    localparam int NIB_W      = 4;
    localparam int PLACE_COLS = 10;
    localparam int PLACE_W    = NIB_W * PLACE_COLS;
    localparam int COUNT_W    = 10;

    typedef logic [ROW_W-1:0]   t_row;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [MAX_N-1:0]   t_rowmask;
    typedef logic [DIAG_W-1:0]  t_diag;
    typedef logic [DIDX_W-1:0]  t_didx;
    typedef logic [SIZE_W-1:0]  t_size;
    typedef logic [NIB_W-1:0]   t_nib;
    typedef logic [COUNT_W-1:0] t_count;

    localparam t_size  SIZE_RESET = t_size'(10);
    localparam t_count COUNT_MAX  = '1;

    typedef struct packed {
        logic start;
        logic step;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic hit;
    } t_stat;

endpackage

// ===== rtl/core/nqse_ctrl.sv =====
// ----------------------------------------------------------------------------
// nqse_ctrl
// Sequencer: takes a request, steps the search until a result is reached and
// moves it into the output register when that is free.
// ----------------------------------------------------------------------------
module nqse_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    input  nqse_pkg::t_stat i_stat,
    output nqse_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_SEARCH = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   out_free;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_cmd.start = accept;
        o_cmd.step  = (r_state == S_SEARCH);
        o_cmd.load  = (r_state == S_SEARCH) && i_stat.hit && out_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (o_cmd.load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_SEARCH))
        else $error("accepted transaction did not start a search");

    a_load_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_out_valid && r_state == S_IDLE))
        else $error("loaded result not presented");

endmodule

// ===== rtl/core/nqse_dpath.sv =====
// ----------------------------------------------------------------------------
// nqse_dpath
// Search datapath: queen stack, occupancy masks, depth and trial counters,
// solution counter and the output register. One search step per cycle.
// ----------------------------------------------------------------------------
module nqse_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [nqse_pkg::SIZE_W-1:0]   i_cfg_data,
    input  logic                          i_restart,
    input  nqse_pkg::t_cmd                i_cmd,
    output nqse_pkg::t_stat               o_stat,
    output logic [nqse_pkg::PLACE_W-1:0]  o_placement,
    output logic [nqse_pkg::COUNT_W-1:0]  o_solution_count,
    output logic                          o_exhausted
);

    nqse_pkg::t_size    r_board_size;
    nqse_pkg::t_row     r_stack [nqse_pkg::MAX_N];
    nqse_pkg::t_rowmask r_rows;
    nqse_pkg::t_diag    r_diags;
    nqse_pkg::t_diag    r_antis;
    nqse_pkg::t_cnt     r_depth;
    nqse_pkg::t_cnt     r_trial;
    nqse_pkg::t_count   r_found;
    logic               r_finished;
    logic               r_first;

    nqse_pkg::t_cnt     n_act;
    nqse_pkg::t_cnt     tb_col;
    nqse_pkg::t_row     tb_row;
    logic               hit;
    logic               tb_first;
    logic               row_end;
    logic               is_tb;
    nqse_pkg::t_cnt     sel_col;
    nqse_pkg::t_cnt     sel_row;
    nqse_pkg::t_rowmask rb;
    nqse_pkg::t_diag    db;
    nqse_pkg::t_diag    ab;
    logic               conflict;
    nqse_pkg::t_count   cnt_inc;
    logic [nqse_pkg::PLACE_W-1:0] packed_place;

    always_comb begin
        if (r_board_size == '0) begin
            n_act = nqse_pkg::t_cnt'(1);
        end else if (int'(r_board_size) > nqse_pkg::MAX_N) begin
            n_act = nqse_pkg::t_cnt'(nqse_pkg::MAX_N);
        end else begin
            n_act = nqse_pkg::t_cnt'(r_board_size);
        end
    end

    assign hit      = r_finished || (!r_first && (r_depth >= n_act));
    assign tb_first = r_first && !r_finished && (r_depth >= n_act);
    assign row_end  = (r_trial >= n_act);
    assign is_tb    = tb_first || (row_end && (r_depth != '0));

    assign tb_col  = r_depth - nqse_pkg::t_cnt'(1);
    assign tb_row  = r_stack[tb_col[nqse_pkg::ROW_W-1:0]];
    assign sel_col = is_tb ? tb_col : r_depth;
    assign sel_row = is_tb ? nqse_pkg::t_cnt'(tb_row) : r_trial;

    always_comb begin
        rb = nqse_pkg::t_rowmask'(1) << sel_row;
        db = nqse_pkg::t_diag'(1) << (nqse_pkg::t_didx'(sel_col)
             + nqse_pkg::t_didx'(nqse_pkg::MAX_N - 1) - nqse_pkg::t_didx'(sel_row));
        ab = nqse_pkg::t_diag'(1) << (nqse_pkg::t_didx'(sel_col)
             + nqse_pkg::t_didx'(sel_row));
    end

    assign conflict = |(r_rows & rb) || |(r_diags & db) || |(r_antis & ab);
    assign cnt_inc  = (r_found == nqse_pkg::COUNT_MAX) ? r_found
                                                       : r_found + nqse_pkg::t_count'(1);

    for (genvar g = 0; g < nqse_pkg::PLACE_COLS; g++) begin : g_pack
        if (g < nqse_pkg::MAX_N) begin : g_col
            assign packed_place[g*nqse_pkg::NIB_W +: nqse_pkg::NIB_W] =
                (nqse_pkg::t_cnt'(g) < r_depth) ? nqse_pkg::t_nib'(r_stack[g]) : '0;
        end else begin : g_none
            assign packed_place[g*nqse_pkg::NIB_W +: nqse_pkg::NIB_W] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_board_size <= nqse_pkg::SIZE_RESET;
            r_rows       <= '0;
            r_diags      <= '0;
            r_antis      <= '0;
            r_depth      <= '0;
            r_trial      <= '0;
            r_found      <= '0;
            r_finished   <= 1'b0;
            r_first      <= 1'b0;
        end else if (i_cfg_we) begin
            r_board_size <= i_cfg_data;
            r_rows       <= '0;
            r_diags      <= '0;
            r_antis      <= '0;
            r_depth      <= '0;
            r_trial      <= '0;
            r_found      <= '0;
            r_finished   <= 1'b0;
        end else if (i_cmd.start) begin
            r_first <= 1'b1;
            if (i_restart) begin
                r_rows     <= '0;
                r_diags    <= '0;
                r_antis    <= '0;
                r_depth    <= '0;
                r_trial    <= '0;
                r_found    <= '0;
                r_finished <= 1'b0;
            end
        end else if (i_cmd.load) begin
            if (!r_finished) begin
                r_found <= cnt_inc;
            end
        end else if (i_cmd.step && !hit) begin
            r_first <= 1'b0;
            if (is_tb) begin
                r_depth <= tb_col;
                r_rows  <= r_rows & ~rb;
                r_diags <= r_diags & ~db;
                r_antis <= r_antis & ~ab;
                r_trial <= nqse_pkg::t_cnt'(tb_row) + nqse_pkg::t_cnt'(1);
            end else if (row_end) begin
                r_finished <= 1'b1;
            end else if (conflict) begin
                r_trial <= r_trial + nqse_pkg::t_cnt'(1);
            end else begin
                r_rows  <= r_rows | rb;
                r_diags <= r_diags | db;
                r_antis <= r_antis | ab;
                r_depth <= r_depth + nqse_pkg::t_cnt'(1);
                r_trial <= '0;
            end
        end
    end

    // queen stack and result payload: no reset
    always_ff @(posedge i_clk) begin
        if (!i_cfg_we && !i_cmd.start && !i_cmd.load && i_cmd.step && !hit
            && !is_tb && !row_end && !conflict) begin
            r_stack[r_depth[nqse_pkg::ROW_W-1:0]] <= r_trial[nqse_pkg::ROW_W-1:0];
        end
        if (i_cmd.load) begin
            if (r_finished) begin
                o_placement      <= '0;
                o_solution_count <= r_found;
                o_exhausted      <= 1'b1;
            end else begin
                o_placement      <= packed_place;
                o_solution_count <= cnt_inc;
                o_exhausted      <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.hit = hit;
    end

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= n_act)
        else $error("search depth beyond board size");

    a_rows_match_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_rows) == int'(r_depth))
        else $error("row occupancy disagrees with depth");

    a_finished_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |-> (r_depth == '0 && r_rows == '0 && r_diags == '0))
        else $error("finished search with queens on board");

endmodule

// ===== rtl/core/n_queens_solution_enumerator_top.sv =====
// ----------------------------------------------------------------------------
// n_queens_solution_enumerator_top
// Each request returns the next N-queens solution (one 4-bit row per column,
// column 0 lowest) with the running count, or an exhausted flag. A request
// is taken only while no search is running; the result then sits in an
// output register, so a new request may be taken while it waits. A request
// is taken, then runs search steps (a row test, a queen placement or a
// backtrack in the single-step search loop) until a result is reached, which
// is loaded into the output register once that is free. Writing board_size
// (0 acts as 1, values above ten act as ten) clears the search like a
// restart.
// ----------------------------------------------------------------------------
module n_queens_solution_enumerator_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [nqse_pkg::SIZE_W-1:0]   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_restart,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [nqse_pkg::PLACE_W-1:0]  o_placement,
    output logic [nqse_pkg::COUNT_W-1:0]  o_solution_count,
    output logic                          o_exhausted
);

    nqse_pkg::t_cmd  cmd;
    nqse_pkg::t_stat stat;

    nqse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    nqse_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_restart        (i_restart),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_placement      (o_placement),
        .o_solution_count (o_solution_count),
        .o_exhausted      (o_exhausted)
    );

endmodule

// ===== tb/nqse_solution_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nqse_solution_checker
// Watches the board_size writes and both transaction channels of the N-queens
// enumerator. Replays the depth-first queen search for every accepted request
// and compares each returned transaction with the oldest predicted answer.
// ----------------------------------------------------------------------------
module nqse_solution_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [nqse_pkg::SIZE_W-1:0]  i_cfg_data,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic                         i_restart,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic [nqse_pkg::PLACE_W-1:0] i_placement,
    input  logic [nqse_pkg::COUNT_W-1:0] i_solution_count,
    input  logic                         i_exhausted,
    output int                           o_fail_count,
    output int                           o_pending
);

    typedef struct packed {
        logic [nqse_pkg::PLACE_W-1:0] placement;
        logic [nqse_pkg::COUNT_W-1:0] count;
        logic                         exhausted;
    } t_answer;

    t_answer                     awaited_answers[$];
    nqse_pkg::t_nib              queen_col_row[nqse_pkg::MAX_N];
    logic [nqse_pkg::MAX_N-1:0]  rows_used;
    logic [nqse_pkg::DIAG_W-1:0] diags_used;
    logic [nqse_pkg::DIAG_W-1:0] antis_used;
    int                          placed_cols;
    int                          next_row;
    nqse_pkg::t_count            found_count;
    bit                          search_over;
    nqse_pkg::t_size             board_reg;
    int                          mismatches;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        mismatches   = 0;
    end

    function automatic int live_size();
        if (board_reg == 0) begin
            return 1;
        end
        if (board_reg > nqse_pkg::MAX_N) begin
            return nqse_pkg::MAX_N;
        end
        return int'(board_reg);
    endfunction

    task automatic clear_board();
        foreach (queen_col_row[k]) begin
            queen_col_row[k] = '0;
        end
        rows_used   = '0;
        diags_used  = '0;
        antis_used  = '0;
        placed_cols = 0;
        next_row    = 0;
        found_count = '0;
        search_over = 1'b0;
    endtask

    task automatic lift_queen();
        int r;
        placed_cols = placed_cols - 1;
        r = int'(queen_col_row[placed_cols]);
        rows_used[r]                                     = 1'b0;
        diags_used[placed_cols + nqse_pkg::MAX_N - 1 - r] = 1'b0;
        antis_used[placed_cols + r]                      = 1'b0;
        next_row = r + 1;
    endtask

    task automatic next_solution(input logic restart, output t_answer ans);
        int n;
        int c;
        int r;
        int k;
        bit got;
        n   = live_size();
        got = 1'b0;
        ans = '0;
        if (restart) begin
            clear_board();
        end
        if (!search_over && placed_cols >= n) begin
            lift_queen();
        end
        while (!search_over && !got) begin
            c = placed_cols;
            r = next_row;
            if (c >= n) begin
                if (found_count != nqse_pkg::COUNT_MAX) begin
                    found_count = found_count + 1'b1;
                end
                for (k = 0; k < c && k < nqse_pkg::PLACE_COLS; k++) begin
                    ans.placement[nqse_pkg::NIB_W*k +: nqse_pkg::NIB_W] = queen_col_row[k];
                end
                ans.count = found_count;
                got = 1'b1;
            end else if (r >= n) begin
                if (c == 0) begin
                    search_over = 1'b1;
                end else begin
                    lift_queen();
                end
            end else if (rows_used[r] || diags_used[c + nqse_pkg::MAX_N - 1 - r] ||
                         antis_used[c + r]) begin
                next_row = r + 1;
            end else begin
                queen_col_row[c]                        = nqse_pkg::t_nib'(r);
                rows_used[r]                            = 1'b1;
                diags_used[c + nqse_pkg::MAX_N - 1 - r] = 1'b1;
                antis_used[c + r]                       = 1'b1;
                placed_cols = c + 1;
                next_row    = 0;
            end
        end
        if (!got) begin
            ans.count     = found_count;
            ans.exhausted = 1'b1;
        end
    endtask

    task automatic log_miss(input string what, input t_answer want, input t_answer seen);
        mismatches = mismatches + 1;
        if (mismatches <= 10) begin
            $display("%0t %s: exp place=%h cnt=%0d exh=%b, got place=%h cnt=%0d exh=%b",
                     $realtime, what, want.placement, want.count, want.exhausted,
                     seen.placement, seen.count, seen.exhausted);
        end
    endtask

    always @(posedge i_clk) begin
        t_answer want;
        t_answer seen;
        if (!i_rst_n) begin
            board_reg = nqse_pkg::SIZE_RESET;
            clear_board();
            awaited_answers.delete();
        end else begin
            if (i_cfg_we) begin
                board_reg = i_cfg_data;
                clear_board();
            end
            if (i_in_valid && !i_in_stall) begin
                next_solution(i_restart, want);
                awaited_answers.push_back(want);
            end
            if (i_out_valid && !i_out_stall) begin
                seen.placement = i_placement;
                seen.count     = i_solution_count;
                seen.exhausted = i_exhausted;
                if (awaited_answers.size() == 0) begin
                    log_miss("unexpected transaction", '0, seen);
                end else begin
                    want = awaited_answers.pop_front();
                    if (seen.placement !== want.placement ||
                        seen.count !== want.count ||
                        seen.exhausted !== want.exhausted) begin
                        log_miss("mismatch", want, seen);
                    end
                end
            end
        end
        o_pending    <= awaited_answers.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives next/restart requests and board_size writes into the N-queens
// enumerator with random idle gaps and output stalls; a checker beside the
// block predicts every solution and reports the failure count for the verdict.
// ----------------------------------------------------------------------------
module tb_top;

    logic                         i_clk;
    logic                         i_rst_n     = 1'b0;
    logic                         i_cfg_we    = 1'b0;
    logic [nqse_pkg::SIZE_W-1:0]  i_cfg_data  = '0;
    logic                         i_in_valid  = 1'b0;
    logic                         o_in_stall;
    logic                         i_restart   = 1'b0;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    logic [nqse_pkg::PLACE_W-1:0] o_placement;
    logic [nqse_pkg::COUNT_W-1:0] o_solution_count;
    logic                         o_exhausted;

    int fail_count;
    int pending;
    int sent;
    bit calm;

    n_queens_solution_enumerator_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_restart        (i_restart),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_placement      (o_placement),
        .o_solution_count (o_solution_count),
        .o_exhausted      (o_exhausted)
    );

    nqse_solution_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_restart        (i_restart),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_placement      (o_placement),
        .i_solution_count (o_solution_count),
        .i_exhausted      (o_exhausted),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("tb_top failed");
        $finish;
    end

    // half no gap, most others short, a few long
    function automatic int pick_gap();
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 15);
        if (r < 8) begin
            return 0;
        end
        if (r < 14) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            n = pick_gap();
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            repeat ($urandom_range(0, 5)) @(posedge i_clk);
        end
    end

    task automatic send_item(input logic restart);
        int gap;
        i_in_valid <= 1'b1;
        i_restart  <= restart;
        do @(posedge i_clk); while (o_in_stall);
        sent = sent + 1;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_size(input logic [nqse_pkg::SIZE_W-1:0] size);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= size;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        int v;
        int cnt;
        bit long_run;
        sent = 0;
        calm = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset board size, then restart returns the first solution again
        send_item(1'b0);
        send_item(1'b0);
        send_item(1'b1);
        // size zero acts as one: one solution, then repeated exhaustion
        set_size(4'd0);
        repeat (3) send_item(1'b0);
        send_item(1'b1);
        set_size(4'd2);
        send_item(1'b0);
        send_item(1'b1);
        set_size(4'd3);
        send_item(1'b0);
        set_size(4'd4);
        repeat (4) send_item(1'b0);
        // oversize boards clamp to the maximum
        set_size(4'd15);
        send_item(1'b0);
        send_item(1'b1);
        set_size(4'd1);
        send_item(1'b0);
        set_size(4'd10);
        send_item(1'b0);

        sent = 0;
        while (sent < 700) begin
            calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 4) != 0) begin
                v = $urandom_range(0, 19);
                set_size(v < 16 ? nqse_pkg::SIZE_W'(v)
                                : nqse_pkg::SIZE_W'($urandom_range(4, 8)));
            end
            long_run = ($urandom_range(0, 3) == 0);
            cnt = long_run ? $urandom_range(40, 100) : $urandom_range(3, 25);
            repeat (cnt) begin
                send_item(long_run ? 1'b0 : ($urandom_range(0, 19) == 0));
            end
        end
        calm = 1'b0;

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
